FILE: hdl/stmin_pkg.sv
package stmin_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic signed [VALUE_W-1:0] MIN_IDENTITY = 32'sh7FFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE,
    KIND_QUERY,
    KIND_EMPTY
  } kind_e;

  function automatic logic signed [VALUE_W-1:0] min_val(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: hdl/stmin_ram.sv
module stmin_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/stmin_queue.sv
module stmin_queue #(
  parameter int unsigned WIDTH = 56
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  ovf_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (ready_o || pop_i))
    else $error("queue overflow");

  udf_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");

  cnt_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule

FILE: hdl/stmin_front.sv
module stmin_front #(
  parameter int unsigned LEAF_COUNT = 1024,
  parameter int unsigned CW         = 12,
  parameter int unsigned EW         = 2 + 2 * 12 + 32
) (
  input  logic                            s_valid_i,
  input  logic                            command_i,
  input  logic [stmin_pkg::POS_W-1:0]     position_i,
  input  logic [stmin_pkg::VALUE_W-1:0]   new_value_i,
  input  logic [stmin_pkg::POS_W-1:0]     range_left_i,
  input  logic [stmin_pkg::POS_W-1:0]     range_right_i,
  input  logic                            clear_done_i,
  output logic                            s_ready_o,
  input  logic                            q_ready_i,
  output logic                            q_push_o,
  output logic [EW-1:0]                   q_data_o
);
  import stmin_pkg::*;

  localparam logic [31:0] LEAVES = 32'(LEAF_COUNT);

  logic [31:0] pos_w, left_w, right_w, right_clip, lo_w, hi_w;
  kind_e       kind;
  logic        drop;

  assign s_ready_o = q_ready_i & clear_done_i;

  always_comb begin
    pos_w      = 32'(position_i);
    left_w     = 32'(range_left_i);
    right_w    = 32'(range_right_i);
    right_clip = (right_w >= LEAVES) ? (LEAVES - 32'd1) : right_w;
    drop       = 1'b0;
    lo_w       = '0;
    hi_w       = '0;
    if (!command_i) begin
      kind = KIND_UPDATE;
      drop = (pos_w >= LEAVES);
      lo_w = pos_w + LEAVES;
    end else if (left_w > right_clip) begin
      kind = KIND_EMPTY;
    end else begin
      kind = KIND_QUERY;
      lo_w = left_w + LEAVES;
      hi_w = right_clip + LEAVES + 32'd1;
    end
  end

  assign q_push_o = s_valid_i & s_ready_o & ~drop;
  assign q_data_o = {kind, lo_w[CW-1:0], hi_w[CW-1:0], new_value_i};

endmodule

FILE: hdl/stmin_back.sv
module stmin_back #(
  parameter int unsigned LEAF_COUNT = 1024,
  parameter int unsigned AW         = 11,
  parameter int unsigned CW         = 12,
  parameter int unsigned EW         = 2 + 2 * 12 + 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  logic [EW-1:0]                        q_data_i,
  output logic                                 q_pop_o,
  output logic                                 clear_done_o,
  output logic                                 ram_we_o,
  output logic [AW-1:0]                        ram_waddr_o,
  output logic signed [stmin_pkg::VALUE_W-1:0] ram_wdata_o,
  output logic [AW-1:0]                        ram_raddr_o,
  input  logic signed [stmin_pkg::VALUE_W-1:0] ram_rdata_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic signed [stmin_pkg::VALUE_W-1:0] m_minimum_o,
  output logic                                 m_empty_o
);
  import stmin_pkg::*;

  localparam logic [AW-1:0] LAST_NODE = AW'(2 * LEAF_COUNT - 1);
  localparam logic [CW-1:0] ROOT      = CW'(1);
  localparam logic [CW-1:0] TOP_CURS  = CW'(2 * LEAF_COUNT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [CW-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic signed [VALUE_W-1:0] acc_q, acc_d;
  logic                      pend_q, pend_d;
  logic                      empty_q, empty_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_min_q, out_min_d;
  logic                      out_empty_q, out_empty_d;

  kind_e                     q_kind;
  logic [CW-1:0]             q_lo, q_hi;
  logic signed [VALUE_W-1:0] q_value;
  logic [CW-1:0]             parent;
  logic signed [VALUE_W-1:0] merged, taken;
  logic                      slot_free;

  assign q_kind  = kind_e'(q_data_i[EW-1 -: KIND_W]);
  assign q_lo    = q_data_i[VALUE_W+2*CW-1 -: CW];
  assign q_hi    = q_data_i[VALUE_W+CW-1 -: CW];
  assign q_value = q_data_i[VALUE_W-1:0];

  assign parent    = lo_q >> 1;
  assign merged    = min_val(acc_q, ram_rdata_i);
  assign taken     = pend_q ? merged : acc_q;
  assign slot_free = ~out_valid_q | m_ready_i;

  assign clear_done_o = (state_q != ST_CLEAR);
  assign m_valid_o    = out_valid_q;
  assign m_minimum_o  = out_min_q;
  assign m_empty_o    = out_empty_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    empty_d     = empty_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    out_min_d   = out_min_q;
    out_empty_d = out_empty_q;
    q_pop_o     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = MIN_IDENTITY;
    ram_raddr_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == LAST_NODE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_kind)
            KIND_UPDATE: begin
              ram_we_o    = 1'b1;
              ram_waddr_o = q_lo[AW-1:0];
              ram_wdata_o = q_value;
              ram_raddr_o = q_lo[AW-1:0] ^ AW'(1);
              acc_d       = q_value;
              lo_d        = q_lo;
              state_d     = ST_UPD;
            end
            KIND_QUERY: begin
              lo_d    = q_lo;
              hi_d    = q_hi;
              acc_d   = MIN_IDENTITY;
              pend_d  = 1'b0;
              empty_d = 1'b0;
              state_d = ST_QRY;
            end
            default: begin
              acc_d   = MIN_IDENTITY;
              empty_d = 1'b1;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_UPD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = parent[AW-1:0];
        ram_wdata_o = merged;
        ram_raddr_o = parent[AW-1:0] ^ AW'(1);
        acc_d       = merged;
        lo_d        = parent;
        if (parent == ROOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        acc_d  = taken;
        pend_d = 1'b0;
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            ram_raddr_o = lo_q[AW-1:0];
            lo_d        = lo_q + CW'(1);
            pend_d      = 1'b1;
          end else if (hi_q[0]) begin
            ram_raddr_o = hi_q[AW-1:0] - AW'(1);
            hi_d        = hi_q - CW'(1);
            pend_d      = 1'b1;
          end else begin
            lo_d = lo_q >> 1;
            hi_d = hi_q >> 1;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_min_d   = acc_q;
          out_empty_d = empty_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    acc_q       <= acc_d;
    empty_q     <= empty_d;
    out_min_q   <= out_min_d;
    out_empty_q <= out_empty_d;
  end

  clr_pop_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_pop_o)
    else $error("item taken during clearing pass");

  upd_node_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (lo_q > ROOT))
    else $error("update walked past the root");

  qry_cursor_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) |-> (hi_q <= TOP_CURS))
    else $error("query cursor beyond the tree");

  out_src_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside the done state");

  qry_empty_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_min_q == MIN_IDENTITY))
    else $error("empty range with a non-identity minimum");

endmodule

FILE: hdl/segment_tree_range_min_unit.sv
// Range-minimum tree over LEAF_COUNT signed 32-bit positions.
// Input stream (s_axis): tuser carries the command (0 update, 1 query),
// tdata the position, new value and inclusive query range.
// Output stream (m_axis): one transfer per query, none per update; tdata is
// the minimum, tuser flags a range that covers no valid position.
// After reset all 2 * LEAF_COUNT nodes of the node memory are swept to the
// largest signed value, one node per cycle; s_axis_tready stays low meanwhile.
// Items pass a classifier into a two-entry queue; the back end walks the
// tree through a single-port-read node memory with registered read data.
// An update writes the leaf, then climbs one level at a time to the root,
// rewriting each ancestor with the minimum of its two children. A query
// reads the left boundary node, then the right one, where they are odd,
// then shifts up a level; an empty range goes straight to the result.
// A stalled receiver holds the result register; the back end keeps going
// with updates and stops only when a new result finds the register full.
// The queue then fills and s_axis_tready drops.
module segment_tree_range_min_unit #(
  parameter int unsigned LEAF_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] position, [41:10] new_value, [51:42] range_left, [61:52] range_right
  input  logic [stmin_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] minimum
  output logic [stmin_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] range_empty
  output logic                                m_axis_tuser
);
  import stmin_pkg::*;

  localparam int unsigned AW = $clog2(2 * LEAF_COUNT);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = KIND_W + 2 * CW + VALUE_W;

  logic                      q_push, q_ready, q_valid, q_pop, clear_done;
  logic [EW-1:0]             q_in, q_out;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic signed [VALUE_W-1:0] ram_wdata, ram_rdata, minimum;

  stmin_front #(
    .LEAF_COUNT(LEAF_COUNT),
    .CW        (CW),
    .EW        (EW)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .command_i    (s_axis_tuser),
    .position_i   (s_axis_tdata[9:0]),
    .new_value_i  (s_axis_tdata[41:10]),
    .range_left_i (s_axis_tdata[51:42]),
    .range_right_i(s_axis_tdata[61:52]),
    .clear_done_i (clear_done),
    .s_ready_o    (s_axis_tready),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  stmin_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .data_o     (q_out),
    .pop_i      (q_pop)
  );

  stmin_back #(
    .LEAF_COUNT(LEAF_COUNT),
    .AW        (AW),
    .CW        (CW),
    .EW        (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .clear_done_o(clear_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_minimum_o (minimum),
    .m_empty_o   (m_axis_tuser)
  );

  stmin_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(2 * LEAF_COUNT)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tdata = minimum;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import stmin_pkg::*;

  localparam int unsigned LEAVES          = 1024;
  localparam int unsigned IDLE_LIMIT      = 20000;
  localparam int unsigned TAIL_CYCLES     = 64;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned VAL_LSB         = POS_W;
  localparam int unsigned LEFT_LSB        = POS_W + VALUE_W;
  localparam int unsigned RIGHT_LSB       = 2 * POS_W + VALUE_W;

  localparam logic [POS_W-1:0]          LAST_POS      = POS_W'(LEAVES - 1);
  localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] ODD_CONSTANT  = 32'sd1987654321;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] minimum;
    logic                      range_empty;
  } range_result_t;

  class range_min_scoreboard;
    logic signed [VALUE_W-1:0] node_min [2*LEAVES];
    range_result_t             awaited [$];
    int unsigned               mismatches;
    int unsigned               updates;
    int unsigned               queries;
    int unsigned               empties;
    int unsigned               checked;

    function new();
      foreach (node_min[k]) node_min[k] = MIN_IDENTITY;
    endfunction

    function void store_leaf(logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] value);
      int unsigned k;
      k = 32'(pos) + LEAVES;
      node_min[k] = value;
      while (k > 1) begin
        k = k >> 1;
        node_min[k] = (node_min[2*k] < node_min[2*k+1]) ? node_min[2*k] : node_min[2*k+1];
      end
    endfunction

    function logic signed [VALUE_W-1:0] span_min(int unsigned left, int unsigned right);
      logic signed [VALUE_W-1:0] acc;
      int unsigned               lo;
      int unsigned               hi;
      acc = MIN_IDENTITY;
      lo  = left + LEAVES;
      hi  = right + LEAVES + 1;
      while (lo < hi) begin
        if ((lo & 1) != 0) begin
          if (node_min[lo] < acc) acc = node_min[lo];
          lo++;
        end
        if ((hi & 1) != 0) begin
          hi--;
          if (node_min[hi] < acc) acc = node_min[hi];
        end
        lo = lo >> 1;
        hi = hi >> 1;
      end
      return acc;
    endfunction

    function void note_item(cmd_e cmd, logic [S_TDATA_W-1:0] data);
      range_result_t want;
      int unsigned   left;
      int unsigned   right;
      if (cmd == CMD_UPDATE) begin
        store_leaf(data[POS_W-1:0], data[VAL_LSB +: VALUE_W]);
        updates++;
      end else begin
        left  = 32'(data[LEFT_LSB +: POS_W]);
        right = 32'(data[RIGHT_LSB +: POS_W]);
        if (right >= LEAVES) right = LEAVES - 1;
        if (left > right) begin
          want.minimum     = MIN_IDENTITY;
          want.range_empty = 1'b1;
          empties++;
        end else begin
          want.minimum     = span_min(left, right);
          want.range_empty = 1'b0;
        end
        awaited.push_back(want);
        queries++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic flag);
      range_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected transfer: minimum %0d range_empty %0b", $signed(data), flag);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        checked++;
        if (data !== want.minimum) begin
          $error("minimum: expected %0d, actual %0d", want.minimum, $signed(data));
          mismatches++;
        end
        if (flag !== want.range_empty) begin
          $error("range_empty: expected %0b, actual %0b", want.range_empty, flag);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;

  range_min_scoreboard sb = new();
  int unsigned         src_idle_pct   = 0;
  int unsigned         sink_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  logic [POS_W-1:0]    hot_base       = '0;

  segment_tree_range_min_unit #(
    .LEAF_COUNT(LEAVES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (s_axis_tvalid && s_axis_tready) sb.note_item(cmd_e'(s_axis_tuser), s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [S_TDATA_W-1:0] pack_fields(
    logic [POS_W-1:0]          pos,
    logic signed [VALUE_W-1:0] value,
    logic [POS_W-1:0]          left,
    logic [POS_W-1:0]          right
  );
    return {2'b00, right, left, value, pos};
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MOST_NEGATIVE;
      1:       return MIN_IDENTITY;
      2:       return $signed($urandom_range(16)) - 8;
      3:       return ODD_CONSTANT;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [S_TDATA_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.awaited.size() != 0);
  endtask

  task automatic run_directed();
    send_item(CMD_QUERY,  pack_fields(0, 0, 0, LAST_POS));
    send_item(CMD_QUERY,  pack_fields(0, 0, 5, 4));
    send_item(CMD_QUERY,  pack_fields(0, 0, LAST_POS, 0));
    send_item(CMD_UPDATE, pack_fields(1, ODD_CONSTANT, 0, 0));
    send_item(CMD_UPDATE, pack_fields(LAST_POS, -1, 0, 0));
    send_item(CMD_UPDATE, pack_fields(512, 0, 0, 0));
    send_item(CMD_UPDATE, pack_fields(511, 5, 0, 0));
    send_item(CMD_QUERY,  pack_fields(0, 0, 0, LAST_POS));
    send_item(CMD_QUERY,  pack_fields(0, 0, 1, 1));
    send_item(CMD_QUERY,  pack_fields(0, 0, 511, 512));
    send_item(CMD_QUERY,  pack_fields(0, 0, 0, 0));
    send_item(CMD_UPDATE, pack_fields(0, MOST_NEGATIVE, 0, 0));
    send_item(CMD_QUERY,  pack_fields(0, 0, 0, LAST_POS));
    send_item(CMD_QUERY,  pack_fields(0, 0, 1, LAST_POS - 1'b1));
    send_item(CMD_QUERY,  pack_fields(0, 0, LAST_POS, LAST_POS));
    send_item(CMD_UPDATE, pack_fields(0, MIN_IDENTITY, '1, '1));
    send_item(CMD_QUERY,  pack_fields('1, '1, 0, LAST_POS));
    send_item(CMD_UPDATE, pack_fields(513, MOST_NEGATIVE, '1, '1));
    send_item(CMD_QUERY,  pack_fields('1, '1, 513, 513));
    send_item(CMD_QUERY,  pack_fields(0, 0, 514, LAST_POS - 1'b1));
    send_item(CMD_QUERY,  pack_fields(0, 0, LAST_POS, LAST_POS - 1'b1));
  endtask

  task automatic send_random();
    logic [POS_W-1:0]          pos;
    logic [POS_W-1:0]          left;
    logic [POS_W-1:0]          right;
    logic [POS_W-1:0]          swap;
    logic signed [VALUE_W-1:0] value;
    pos   = POS_W'($urandom);
    value = $urandom;
    left  = POS_W'($urandom);
    right = POS_W'($urandom);
    if ($urandom_range(99) < 55) begin
      if ($urandom_range(1) != 0) pos = hot_base + POS_W'($urandom_range(63));
      send_item(CMD_UPDATE, pack_fields(pos, pick_value(), left, right));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          left  = hot_base + POS_W'($urandom_range(63));
          right = left + POS_W'($urandom_range(63));
        end
        4: left = '0;
        5: right = LAST_POS;
        6: right = left;
        7: begin
          if (left < right) begin
            swap  = left;
            left  = right;
            right = swap;
          end
          if (left == right) begin
            if (right == '0) left = POS_W'(1);
            else right = right - 1'b1;
          end
        end
        default: ;
      endcase
      send_item(CMD_QUERY, pack_fields(pos, value, left, right));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 7;  sink_stall_pct = 7;  end
      endcase
      hot_base = POS_W'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) == 0) hold_until_drained();
        send_random();
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d updates and %0d queries (%0d empty ranges); %0d results checked.",
             sb.updates, sb.queries, sb.empties, sb.checked);
    $display("Flow phases: free running, sender gaps, receiver stalls, light mix; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
